FILE: hdl/page_frame_replacement_engine_defines.svh
// Assertion macros for the page frame replacement engine
`ifndef PAGE_FRAME_REPLACEMENT_ENGINE_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PFRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PFRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pfre_pkg.sv
// Shared constants, codes and types of the page frame replacement engine
`timescale 1ns / 1ps
`default_nettype none
package pfre_pkg;

   localparam int FRAMES     = 128;
   localparam int FRAME_W    = $clog2(FRAMES);
   localparam int CNT_W      = FRAME_W + 1;
   localparam int AGE_W      = 32;
   localparam int TIME_W     = 32;
   localparam int RND_W      = 31;
   localparam int DIV_STEPS  = RND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};

   // Replacement policies
   localparam logic [2:0] POL_FIFO   = 3'd0;
   localparam logic [2:0] POL_RANDOM = 3'd1;
   localparam logic [2:0] POL_CLOCK  = 3'd2;
   localparam logic [2:0] POL_NRU    = 3'd3;
   localparam logic [2:0] POL_AGING  = 3'd4;
   localparam logic [2:0] POL_WS     = 3'd5;

   // Request kinds
   localparam logic [1:0] REQ_ACCESS  = 2'd0;
   localparam logic [1:0] REQ_ALLOC   = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NRU_INT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WS_TAU   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP,
      ST_DIV,
      ST_CLOCK,
      ST_NRU,
      ST_AGE_RD,
      ST_AGE_WR,
      ST_MIN_RD,
      ST_MIN_CMP,
      ST_WS_RD,
      ST_WS_CMP,
      ST_GRANT
   } state_type;

   // Frame table write port
   typedef struct packed {
      logic               age_en;
      logic               lu_en;
      logic [FRAME_W-1:0] addr;
      logic [AGE_W-1:0]   age;
      logic [TIME_W-1:0]  lu;
   } tbl_wr_type;

   // Release queue control
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [FRAME_W-1:0] data;
   } fifo_ctl_type;

   // Modulo unit request
   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } mod_req_type;

endpackage
`default_nettype wire

FILE: hdl/pfre_modulo.sv
// Bit-serial restoring modulo unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pfre_modulo (
   input  wire                          clock,
   input  wire                          reset,
   input  pfre_pkg::mod_req_type        req,
   output logic                         done,
   output logic [pfre_pkg::FRAME_W-1:0] remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pfre_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pfre_pkg::RND_W-1:0]     div_ff, div_in;
   logic [pfre_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [pfre_pkg::CNT_W-1:0]     dsr_ff, dsr_in;
   logic [pfre_pkg::CNT_W-1:0]     trial;

   // Shift in the next dividend bit
   assign trial = {rem_ff[pfre_pkg::FRAME_W-1:0], div_ff[pfre_pkg::RND_W-1]};

   // Step the division
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= dsr_ff) ? trial - dsr_ff : trial;
         div_in = {div_ff[pfre_pkg::RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pfre_pkg::DIV_CNT_W'(pfre_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[pfre_pkg::FRAME_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/pfre_frame_table.sv
// Per-frame age and last-use memories with reset-cleared valid bits
`timescale 1ns / 1ps
`default_nettype none
module pfre_frame_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire  [pfre_pkg::FRAME_W-1:0] rd_addr,
   input  pfre_pkg::tbl_wr_type         wr,
   output logic [pfre_pkg::AGE_W-1:0]   rd_age,
   output logic [pfre_pkg::TIME_W-1:0]  rd_lu
);

   logic [pfre_pkg::AGE_W-1:0]  age_mem [pfre_pkg::FRAMES];
   logic [pfre_pkg::TIME_W-1:0] lu_mem  [pfre_pkg::FRAMES];
   logic [pfre_pkg::FRAMES-1:0] age_vld_ff;
   logic [pfre_pkg::FRAMES-1:0] lu_vld_ff;
   logic [pfre_pkg::AGE_W-1:0]  age_q_ff;
   logic [pfre_pkg::TIME_W-1:0] lu_q_ff;
   logic                        age_qv_ff;
   logic                        lu_qv_ff;

   // Write entries
   always_ff @(posedge clock) begin
      if (wr.age_en) age_mem[wr.addr] <= wr.age;
      if (wr.lu_en)  lu_mem[wr.addr]  <= wr.lu;
   end

   // Track written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         age_vld_ff <= '0;
         lu_vld_ff  <= '0;
      end else begin
         if (wr.age_en) age_vld_ff[wr.addr] <= 1'b1;
         if (wr.lu_en)  lu_vld_ff[wr.addr]  <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         age_q_ff  <= age_mem[rd_addr];
         lu_q_ff   <= lu_mem[rd_addr];
         age_qv_ff <= age_vld_ff[rd_addr];
         lu_qv_ff  <= lu_vld_ff[rd_addr];
      end
   end

   // Unwritten entries read as zero
   assign rd_age = age_qv_ff ? age_q_ff : '0;
   assign rd_lu  = lu_qv_ff ? lu_q_ff : '0;

endmodule
`default_nettype wire

FILE: hdl/pfre_release_fifo.sv
// Queue of released frames, oldest handed out first
`timescale 1ns / 1ps
`default_nettype none
module pfre_release_fifo (
   input  wire                          clock,
   input  wire                          reset,
   input  pfre_pkg::fifo_ctl_type       ctl,
   output logic [pfre_pkg::CNT_W-1:0]   count,
   output logic [pfre_pkg::FRAME_W-1:0] pop_data
);

   logic [pfre_pkg::FRAME_W-1:0] mem [pfre_pkg::FRAMES];
   logic [pfre_pkg::FRAME_W-1:0] head_ff;
   logic [pfre_pkg::FRAME_W-1:0] tail_ff;
   logic [pfre_pkg::CNT_W-1:0]   count_ff;
   logic [pfre_pkg::FRAME_W-1:0] data_ff;

   // Store pushed frames, read head on pop
   always_ff @(posedge clock) begin
      if (ctl.push) mem[tail_ff] <= ctl.data;
      if (ctl.pop)  data_ff <= mem[head_ff];
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (ctl.push) begin
            tail_ff  <= tail_ff + 1'b1;
            count_ff <= count_ff + 1'b1;
         end else if (ctl.pop) begin
            head_ff  <= head_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign count    = count_ff;
   assign pop_data = data_ff;

endmodule
`default_nettype wire

FILE: hdl/page_frame_replacement_engine.sv
// Access and release go back to back with no result. A never-used frame is allocated via the
// grant state; a queued one via the pop state (queue read), then grant. Victim allocation:
// the shared bit-serial modulo unit (hand or random mod n), then a scan (none for FIFO or
// random; clock, NRU and working set step the frames; aging updates, then seeks the minimum),
// then grant. One transaction at a time; the next is taken once the grant is placed in the
// output register. Synchronous reset clears frame bits, ages, times, hand, counts, queue.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_replacement_engine_defines.svh"
module page_frame_replacement_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [1:0]                       req_type,
   input  wire  [6:0]                       req_frame_sel,
   input  wire                              req_mark_modified,
   input  wire  [31:0]                      req_now,
   input  wire  [30:0]                      req_random_value,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [6:0]                       rsp_frame_out,
   output logic                             rsp_from_free_pool,
   output logic                             rsp_victim_dirty,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [pfre_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [pfre_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FW = pfre_pkg::FRAME_W;
   localparam int CW = pfre_pkg::CNT_W;

   pfre_pkg::state_type state_ff, state_in;

   logic [2:0]                     policy_ff;
   logic [7:0]                     active_ff;
   logic [31:0]                    nru_int_ff;
   logic [31:0]                    ws_tau_ff;

   logic [pfre_pkg::FRAMES-1:0]    ref_ff, ref_in;
   logic [pfre_pkg::FRAMES-1:0]    mod_ff, mod_in;
   logic [FW-1:0]                  hand_ff, hand_in;
   logic [31:0]                    last_nru_ff, last_nru_in;
   logic [CW-1:0]                  fresh_ff, fresh_in;
   logic [31:0]                    now_ff, now_in;
   logic [FW-1:0]                  cur_ff, cur_in;
   logic [CW:0]                    cnt_ff, cnt_in;
   logic [FW-1:0]                  victim_ff, victim_in;
   logic [31:0]                    best_ff, best_in;
   logic [3:0]                     seen_ff, seen_in;
   logic [FW-1:0]                  first_ff [4];
   logic [FW-1:0]                  first_in [4];
   logic [FW-1:0]                  grant_ff, grant_in;
   logic                           pool_ff, pool_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                  rsp_frame_ff, rsp_frame_in;
   logic                           rsp_pool_ff, rsp_pool_in;
   logic                           rsp_dirty_ff, rsp_dirty_in;

   logic [CW-1:0]                  frame_n;
   logic                           nru_due;
   logic [1:0]                     cur_cls;
   logic                           out_free;
   logic [31:0]                    ws_age;
   logic [FW-1:0]                  cur_next;
   logic                           last_step;
   logic                           req_acc;
   logic                           sel_ok;
   logic                           grant_go;
   logic                           grant_done;
   logic                           mod_in_range;

   pfre_pkg::tbl_wr_type           tbl_wr;
   logic                           tbl_rd_en;
   logic [pfre_pkg::AGE_W-1:0]     tbl_age;
   logic [pfre_pkg::TIME_W-1:0]    tbl_lu;
   pfre_pkg::fifo_ctl_type         fifo_ctl;
   logic [CW-1:0]                  fifo_count;
   logic [FW-1:0]                  fifo_data;
   pfre_pkg::mod_req_type          mod_req;
   logic                           mod_done;
   logic [FW-1:0]                  mod_rem;

   // Step a frame index around the active range
   function automatic logic [FW-1:0] wrap_next(input logic [FW-1:0] idx,
                                               input logic [CW-1:0] n);
      logic [CW-1:0] nx;
      nx = {1'b0, idx} + 1'b1;
      return (nx == n) ? '0 : nx[FW-1:0];
   endfunction

   // Clamp the active frame count to 1..FRAMES
   always_comb begin
      if (active_ff == 8'd0) begin
         frame_n = CW'(1);
      end else if (active_ff > 8'(pfre_pkg::FRAMES)) begin
         frame_n = CW'(pfre_pkg::FRAMES);
      end else begin
         frame_n = CW'(active_ff);
      end
   end

   assign nru_due   = (now_ff - last_nru_ff) >= nru_int_ff;
   assign cur_cls   = {ref_ff[cur_ff], mod_ff[cur_ff]};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ws_age    = now_ff - tbl_lu;
   assign cur_next  = wrap_next(cur_ff, frame_n);
   assign last_step = (cnt_ff == ({1'b0, frame_n} - 1'b1));
   assign req_acc   = req_valid && req_ready;
   assign sel_ok    = ({1'b0, req_frame_sel} < frame_n);

   assign req_ready = (state_ff == pfre_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      mod_in       = mod_ff;
      hand_in      = hand_ff;
      last_nru_in  = last_nru_ff;
      fresh_in     = fresh_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      grant_in     = grant_ff;
      pool_in      = pool_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_pool_in  = rsp_pool_ff;
      rsp_dirty_in = rsp_dirty_ff;
      tbl_wr       = '0;
      tbl_rd_en    = 1'b0;
      fifo_ctl     = '0;
      mod_req      = '0;
      mod_req.divisor = frame_n;

      case (state_ff)
         pfre_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  pfre_pkg::REQ_ACCESS: begin
                     if (sel_ok) begin
                        ref_in[req_frame_sel] = 1'b1;
                        if (req_mark_modified) mod_in[req_frame_sel] = 1'b1;
                     end
                  end
                  pfre_pkg::REQ_RELEASE: begin
                     if (sel_ok && fifo_count < CW'(pfre_pkg::FRAMES)) begin
                        ref_in[req_frame_sel] = 1'b0;
                        mod_in[req_frame_sel] = 1'b0;
                        fifo_ctl.push = 1'b1;
                        fifo_ctl.data = req_frame_sel;
                     end
                  end
                  pfre_pkg::REQ_ALLOC: begin
                     now_in = req_now;
                     if (fresh_ff < frame_n) begin
                        grant_in = fresh_ff[FW-1:0];
                        fresh_in = fresh_ff + 1'b1;
                        pool_in  = 1'b1;
                        state_in = pfre_pkg::ST_GRANT;
                     end else if (fifo_count != '0) begin
                        fifo_ctl.pop = 1'b1;
                        state_in     = pfre_pkg::ST_POP;
                     end else begin
                        // Reduce random value or hand mod n
                        mod_req.start    = 1'b1;
                        mod_req.dividend = (policy_ff == pfre_pkg::POL_RANDOM) ?
                                           req_random_value :
                                           pfre_pkg::RND_W'(hand_ff);
                        pool_in  = 1'b0;
                        state_in = pfre_pkg::ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         pfre_pkg::ST_POP: begin
            grant_in = fifo_data;
            pool_in  = 1'b1;
            state_in = pfre_pkg::ST_GRANT;
         end

         pfre_pkg::ST_DIV: begin
            if (mod_done) begin
               cur_in    = mod_rem;
               cnt_in    = '0;
               victim_in = mod_rem;
               best_in   = '1;
               seen_in   = '0;
               case (policy_ff)
                  pfre_pkg::POL_RANDOM: begin
                     grant_in = mod_rem;
                     state_in = pfre_pkg::ST_GRANT;
                  end
                  pfre_pkg::POL_CLOCK: state_in = pfre_pkg::ST_CLOCK;
                  pfre_pkg::POL_NRU:   state_in = pfre_pkg::ST_NRU;
                  pfre_pkg::POL_AGING: state_in = pfre_pkg::ST_AGE_RD;
                  pfre_pkg::POL_WS: begin
                     best_in  = '0;
                     state_in = pfre_pkg::ST_WS_RD;
                  end
                  default: begin
                     grant_in = mod_rem;
                     hand_in  = wrap_next(mod_rem, frame_n);
                     state_in = pfre_pkg::ST_GRANT;
                  end
               endcase
            end
         end

         // Clear referenced bits until an unreferenced frame turns up
         pfre_pkg::ST_CLOCK: begin
            if (!ref_ff[cur_ff] || cnt_ff == {frame_n, 1'b0}) begin
               grant_in = cur_ff;
               hand_in  = cur_next;
               state_in = pfre_pkg::ST_GRANT;
            end else begin
               ref_in[cur_ff] = 1'b0;
               cur_in         = cur_next;
               cnt_in         = cnt_ff + 1'b1;
            end
         end

         // Note the first frame of each class; grant a class-0 frame at once unless an NRU clear is due
         pfre_pkg::ST_NRU: begin
            if (!seen_ff[cur_cls]) begin
               seen_in[cur_cls]  = 1'b1;
               first_in[cur_cls] = cur_ff;
            end
            if (cur_cls == 2'd0 && !nru_due) begin
               grant_in = cur_ff;
               hand_in  = cur_next;
               state_in = pfre_pkg::ST_GRANT;
            end else begin
               if (nru_due) ref_in[cur_ff] = 1'b0;
               cur_in = cur_next;
               cnt_in = cnt_ff + 1'b1;
               if (last_step) begin
                  if (seen_in[0]) begin
                     grant_in = first_in[0];
                  end else if (seen_in[1]) begin
                     grant_in = first_in[1];
                  end else if (seen_in[2]) begin
                     grant_in = first_in[2];
                  end else begin
                     grant_in = first_in[3];
                  end
                  hand_in = wrap_next(grant_in, frame_n);
                  if (nru_due) last_nru_in = now_ff;
                  state_in = pfre_pkg::ST_GRANT;
               end
            end
         end

         pfre_pkg::ST_AGE_RD: begin
            tbl_rd_en = 1'b1;
            state_in  = pfre_pkg::ST_AGE_WR;
         end

         // Shift age, fold in referenced bit
         pfre_pkg::ST_AGE_WR: begin
            tbl_wr.age_en  = 1'b1;
            tbl_wr.addr    = cur_ff;
            tbl_wr.age     = (tbl_age >> 1) | (ref_ff[cur_ff] ? pfre_pkg::AGE_TOP : '0);
            ref_in[cur_ff] = 1'b0;
            cur_in         = cur_next;
            cnt_in         = cnt_ff + 1'b1;
            state_in       = pfre_pkg::ST_AGE_RD;
            if (last_step) begin
               cnt_in   = '0;
               state_in = pfre_pkg::ST_MIN_RD;
            end
         end

         pfre_pkg::ST_MIN_RD: begin
            tbl_rd_en = 1'b1;
            state_in  = pfre_pkg::ST_MIN_CMP;
         end

         // Keep the first smallest age
         pfre_pkg::ST_MIN_CMP: begin
            if (tbl_age < best_ff) begin
               best_in   = tbl_age;
               victim_in = cur_ff;
            end
            cur_in   = cur_next;
            cnt_in   = cnt_ff + 1'b1;
            state_in = pfre_pkg::ST_MIN_RD;
            if (last_step) begin
               grant_in = victim_in;
               hand_in  = wrap_next(victim_in, frame_n);
               state_in = pfre_pkg::ST_GRANT;
            end
         end

         pfre_pkg::ST_WS_RD: begin
            tbl_rd_en = 1'b1;
            state_in  = pfre_pkg::ST_WS_CMP;
         end

         // Evict an old unreferenced frame, refresh referenced ones
         pfre_pkg::ST_WS_CMP: begin
            if (!ref_ff[cur_ff] && ws_age > ws_tau_ff) begin
               grant_in = cur_ff;
               hand_in  = cur_next;
               state_in = pfre_pkg::ST_GRANT;
            end else begin
               if (ref_ff[cur_ff]) begin
                  tbl_wr.lu_en   = 1'b1;
                  tbl_wr.addr    = cur_ff;
                  tbl_wr.lu      = now_ff;
                  ref_in[cur_ff] = 1'b0;
               end else if (ws_age > best_ff) begin
                  best_in   = ws_age;
                  victim_in = cur_ff;
               end
               cur_in   = cur_next;
               cnt_in   = cnt_ff + 1'b1;
               state_in = pfre_pkg::ST_WS_RD;
               if (last_step) begin
                  grant_in = victim_in;
                  hand_in  = wrap_next(victim_in, frame_n);
                  state_in = pfre_pkg::ST_GRANT;
               end
            end
         end

         // Map the granted frame and load the output register
         pfre_pkg::ST_GRANT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_frame_in     = grant_ff;
               rsp_pool_in      = pool_ff;
               rsp_dirty_in     = !pool_ff && mod_ff[grant_ff];
               ref_in[grant_ff] = 1'b1;
               mod_in[grant_ff] = 1'b0;
               tbl_wr.age_en    = 1'b1;
               tbl_wr.lu_en     = 1'b1;
               tbl_wr.addr      = grant_ff;
               tbl_wr.age       = '0;
               tbl_wr.lu        = now_ff;
               state_in         = pfre_pkg::ST_IDLE;
            end
         end

         default: state_in = pfre_pkg::ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and frame bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= '0;
         mod_ff       <= '0;
         hand_ff      <= '0;
         last_nru_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_ff       <= ref_in;
         mod_ff       <= mod_in;
         hand_ff      <= hand_in;
         last_nru_ff  <= last_nru_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan working registers and result payload
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      victim_ff    <= victim_in;
      best_ff      <= best_in;
      seen_ff      <= seen_in;
      first_ff     <= first_in;
      grant_ff     <= grant_in;
      pool_ff      <= pool_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_pool_ff  <= rsp_pool_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= pfre_pkg::POL_FIFO;
         active_ff  <= 8'd128;
         nru_int_ff <= 32'd48;
         ws_tau_ff  <= 32'd49;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pfre_pkg::CSR_POLICY:  policy_ff  <= csr_wdata[2:0];
            pfre_pkg::CSR_ACTIVE:  active_ff  <= csr_wdata[7:0];
            pfre_pkg::CSR_NRU_INT: nru_int_ff <= csr_wdata;
            pfre_pkg::CSR_WS_TAU:  ws_tau_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pfre_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .req       (mod_req),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   pfre_frame_table u_frame_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (cur_ff),
      .wr      (tbl_wr),
      .rd_age  (tbl_age),
      .rd_lu   (tbl_lu)
   );

   pfre_release_fifo u_release_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fifo_ctl),
      .count    (fifo_count),
      .pop_data (fifo_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_out      = rsp_frame_ff;
   assign rsp_from_free_pool = rsp_pool_ff;
   assign rsp_victim_dirty   = rsp_dirty_ff;

   // Conditions watched by the checks below
   assign grant_go     = (state_ff == pfre_pkg::ST_GRANT) && out_free;
   assign grant_done   = rsp_valid_ff && (state_ff == pfre_pkg::ST_IDLE);
   assign mod_in_range = ({1'b0, mod_rem} < frame_n);

   `PFRE_ASSERT_NOW(a_pool_clean, clock, reset, rsp_valid_ff && rsp_pool_ff, !rsp_dirty_ff, "free frame reported dirty")
   `PFRE_ASSERT_NOW(a_mod_range, clock, reset, mod_done, mod_in_range, "modulo result out of range")
   `PFRE_ASSERT_NEXT(a_grant_out, clock, reset, grant_go, grant_done, "grant not delivered")

endmodule
`default_nettype wire
